@@ src/srtd_pkg.sv @@
// Shared constants and types for the signed digit-recurrence divider.
`timescale 1ns / 1ps

package srtd_pkg;

    // Default operand width of the divider.
    localparam int SRTD_WIDTH = 8;

    // Sign and error flags that travel with every operand pair down the pipeline.
    typedef struct packed {
        logic neg_q;   // quotient must be negated at the end
        logic neg_r;   // remainder must be negated at the end
        logic err;     // division by zero or quotient overflow
    } t_sign_flags;

endpackage

@@ src/srt_radix2_signed_divider_core.sv @@
// Top level of the pipelined signed divider.
//
// Usage: operand pairs enter on the input channel (i_in_valid / o_in_ready,
// i_dividend, i_divisor) and results leave on the output channel
// (o_out_valid / i_out_ready, o_quotient, o_remainder, o_div_error).
// The quotient is truncated toward zero and the remainder takes the sign of
// the dividend. Division by zero and the most negative dividend over minus
// one set o_div_error and give zero quotient and remainder.
// An accepted input beat passes through these stages to its result beat:
// one operand stage, one register stage for each of the WIDTH quotient digits
// and one output stage. A new beat may enter in every cycle, so throughput is
// one division per cycle while the receiver takes results.
// Each stage holds its beat when the stage after it is full and stalled, so
// a stalled receiver backs the pipeline up one stage at a time; empty stages
// still take beats, and nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline; no results are pending
// after it and the block takes input in the next cycle.
`timescale 1ns / 1ps

module srt_radix2_signed_divider_core
    import srtd_pkg::*;
#(
    parameter int WIDTH = SRTD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder,
    output logic             o_div_error
);

    // Links between stages; index 0 is the operand stage output.
    logic             w_valid [0:WIDTH];
    logic             w_ready [0:WIDTH];
    logic [WIDTH-1:0] w_rem   [0:WIDTH];
    logic [WIDTH-1:0] w_qd    [0:WIDTH];
    logic [WIDTH-1:0] w_dsr   [0:WIDTH];
    t_sign_flags      w_flags [0:WIDTH];

    // Operand stage.
    srtd_prep #(
        .WIDTH (WIDTH)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_rem      (w_rem[0]),
        .o_qd       (w_qd[0]),
        .o_dsr      (w_dsr[0]),
        .o_flags    (w_flags[0])
    );

    // One recurrence stage per quotient digit.
    for (genvar g = 0; g < WIDTH; g++) begin : g_step
        srtd_step #(
            .WIDTH (WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_rem   (w_rem[g]),
            .i_qd    (w_qd[g]),
            .i_dsr   (w_dsr[g]),
            .i_flags (w_flags[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_qd    (w_qd[g+1]),
            .o_dsr   (w_dsr[g+1]),
            .o_flags (w_flags[g+1])
        );
    end

    // Sign correction and output register.
    srtd_fix #(
        .WIDTH (WIDTH)
    ) u_fix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[WIDTH]),
        .o_ready     (w_ready[WIDTH]),
        .i_rem       (w_rem[WIDTH]),
        .i_qd        (w_qd[WIDTH]),
        .i_flags     (w_flags[WIDTH]),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder),
        .o_div_error (o_div_error)
    );

    // The divisor magnitude is not needed after the last digit.
    logic w_dsr_unused;
    assign w_dsr_unused = ^w_dsr[WIDTH];

endmodule

@@ src/srtd_prep.sv @@
// Input stage: takes magnitudes of the operands, sets sign and error flags.
`timescale 1ns / 1ps

module srtd_prep
    import srtd_pkg::*;
#(
    parameter int WIDTH = SRTD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH-1:0] o_qd,
    output logic [WIDTH-1:0] o_dsr,
    output t_sign_flags      o_flags
);

    localparam logic [WIDTH-1:0] MostNeg = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MinusOne = {WIDTH{1'b1}};

    logic             r_valid;
    logic [WIDTH-1:0] r_qd;
    logic [WIDTH-1:0] r_dsr;
    t_sign_flags      r_flags;

    logic [WIDTH-1:0] n_qd;
    logic [WIDTH-1:0] n_dsr;
    t_sign_flags      n_flags;

    // The stage takes a beat whenever it is empty or its beat moves on.
    assign o_ready = !r_valid || i_ready;

    // Magnitudes; the most negative value maps onto its unsigned magnitude.
    always_comb begin
        n_qd          = i_dividend[WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
        n_dsr         = i_divisor[WIDTH-1] ? (~i_divisor + 1'b1) : i_divisor;
        n_flags.neg_q = i_dividend[WIDTH-1] ^ i_divisor[WIDTH-1];
        n_flags.neg_r = i_dividend[WIDTH-1];
        n_flags.err   = (i_divisor == '0) ||
                        ((i_dividend == MostNeg) && (i_divisor == MinusOne));
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_qd    <= n_qd;
            r_dsr   <= n_dsr;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = '0;
    assign o_qd    = r_qd;
    assign o_dsr   = r_dsr;
    assign o_flags = r_flags;

endmodule

@@ src/srtd_step.sv @@
// One registered recurrence step: develops one quotient digit per stage.
`timescale 1ns / 1ps

module srtd_step
    import srtd_pkg::*;
#(
    parameter int WIDTH = SRTD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_rem,
    input  logic [WIDTH-1:0] i_qd,
    input  logic [WIDTH-1:0] i_dsr,
    input  t_sign_flags      i_flags,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH-1:0] o_qd,
    output logic [WIDTH-1:0] o_dsr,
    output t_sign_flags      o_flags
);

    logic             r_valid;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_qd;
    logic [WIDTH-1:0] r_dsr;
    t_sign_flags      r_flags;

    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_qd;
    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;

    assign o_ready = !r_valid || i_ready;

    // Shift the next dividend bit into the partial remainder and try the
    // subtraction; a non-negative difference gives a one digit.
    always_comb begin
        w_shift = {i_rem, i_qd[WIDTH-1]};
        w_diff  = w_shift - {1'b0, i_dsr};
        if (!w_diff[WIDTH]) begin
            n_rem = w_diff[WIDTH-1:0];
            n_qd  = {i_qd[WIDTH-2:0], 1'b1};
        end else begin
            n_rem = w_shift[WIDTH-1:0];
            n_qd  = {i_qd[WIDTH-2:0], 1'b0};
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem   <= n_rem;
            r_qd    <= n_qd;
            r_dsr   <= i_dsr;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_qd    = r_qd;
    assign o_dsr   = r_dsr;
    assign o_flags = r_flags;

endmodule

@@ src/srtd_fix.sv @@
// Output stage: restores signs, forces zeros on error and holds the result beat.
`timescale 1ns / 1ps

module srtd_fix
    import srtd_pkg::*;
#(
    parameter int WIDTH = SRTD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_rem,
    input  logic [WIDTH-1:0] i_qd,
    input  t_sign_flags      i_flags,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder,
    output logic             o_div_error
);

    logic             r_valid;
    logic [WIDTH-1:0] r_quotient;
    logic [WIDTH-1:0] r_remainder;
    logic             r_div_error;

    logic [WIDTH-1:0] n_quotient;
    logic [WIDTH-1:0] n_remainder;

    assign o_ready = !r_valid || i_ready;

    // Sign correction of the magnitudes; an error result reads as zero.
    always_comb begin
        n_quotient  = i_flags.neg_q ? (~i_qd + 1'b1) : i_qd;
        n_remainder = i_flags.neg_r ? (~i_rem + 1'b1) : i_rem;
        if (i_flags.err) begin
            n_quotient  = '0;
            n_remainder = '0;
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_quotient  <= n_quotient;
            r_remainder <= n_remainder;
            r_div_error <= i_flags.err;
        end
    end

    assign o_valid     = r_valid;
    assign o_quotient  = r_quotient;
    assign o_remainder = r_remainder;
    assign o_div_error = r_div_error;

endmodule
